FILE: design/osdrf_pkg.sv
// Shared types and constants for the OSD dirty-run frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package osdrf_pkg;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_REDRAW = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_PULL   = 3'd4;

    localparam logic [7:0] CLEAR_CMD_BYTE  = 8'd2;
    localparam logic [7:0] STRING_CMD_BYTE = 8'd3;
    localparam logic [7:0] BLANK_RESET     = 8'd32;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] cell_row;
        logic [6:0] cell_col;
        logic [8:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [8:0] read_code;
        logic       read_ok;
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_item_t;

    typedef enum logic [3:0] {
        RES_ZERO   = 4'd0,
        RES_READ   = 4'd1,
        RES_CLEAR  = 4'd2,
        RES_STRING = 4'd3,
        RES_ROW    = 4'd4,
        RES_COL    = 4'd5,
        RES_INFO   = 4'd6,
        RES_CODE   = 4'd7,
        RES_EMPTY  = 4'd8
    } res_sel_t;

    typedef struct packed {
        logic     sweep_start;
        logic     sweep_redraw;
        logic     sweep_step;
        logic     item_read;
        logic     write_commit;
        logic     find_origin;
        logic     find_next;
        logic     find_issue;
        logic     find_eval;
        logic     run_start;
        logic     run_load;
        logic     run_take;
        logic     run_finish;
        logic     code_issue;
        logic     code_finish;
        logic     res_set;
        res_sel_t res_sel;
        logic     res_mark_last;
        logic     res_push;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       on_screen;
        logic       sweep_last;
        logic       find_found;
        logic       find_exhausted;
        logic       run_more;
        logic       run_single;
        logic       out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

FILE: design/osdrf_datapath.sv
// Datapath: screen store, dirty-row memory, scan and run registers, result registers.
`timescale 1ns / 1ps
`default_nettype none
module osdrf_datapath #(
    parameter int ROWS_N = 22,
    parameter int COLS_N = 60
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_accept,
    input  wire osdrf_pkg::in_item_t s_item,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_wdata,
    input  wire osdrf_pkg::dp_cmd_t  cmd,
    output osdrf_pkg::dp_sts_t       sts,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output osdrf_pkg::out_item_t     m_item
);
    import osdrf_pkg::*;

    localparam int CELLS   = ROWS_N * COLS_N;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_IW  = (ROWS_N > 1) ? $clog2(ROWS_N) : 1;
    localparam int COL_IW  = (COLS_N > 1) ? $clog2(COLS_N) : 1;
    localparam logic [CELL_AW-1:0] LAST_CELL    = CELL_AW'(CELLS - 1);
    localparam logic [CELL_AW-1:0] LAST_ROW_CNT = CELL_AW'(ROWS_N - 1);
    localparam logic [ROW_IW-1:0]  LAST_ROW     = ROW_IW'(ROWS_N - 1);
    localparam logic [7:0]         COLS_LIM     = 8'(COLS_N);
    localparam logic [5:0]         ROWS_LIM     = 6'(ROWS_N);

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_IW-1:0] row,
                                                     input logic [COL_IW-1:0] col);
        cell_addr = CELL_AW'(row) * CELL_AW'(COLS_N) + CELL_AW'(col);
    endfunction

    logic [8:0]        cell_mem [CELLS];
    logic [COLS_N-1:0] dirty_mem [ROWS_N];

    in_item_t          item_reg, item_next;
    logic [7:0]        blank_reg, blank_next;
    logic [CELL_AW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [7:0]        sweep_val_reg, sweep_val_next;
    logic              sweep_redraw_reg, sweep_redraw_next;
    logic [8:0]        cell_q_reg;
    logic [COLS_N-1:0] dirty_q_reg;
    logic [ROW_IW-1:0] scan_row_reg, scan_row_next;
    logic [6:0]        scan_col_reg, scan_col_next;
    logic [ROW_IW-1:0] find_row_reg, find_row_next;
    logic [6:0]        find_col_reg, find_col_next;
    logic [COLS_N-1:0] row_buf_reg, row_buf_next;
    logic [6:0]        len_reg, len_next;
    logic [6:0]        run_left_reg, run_left_next;
    logic              run_ext_reg, run_ext_next;
    out_item_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic               item_inside;
    logic [ROW_IW-1:0]  item_row_i;
    logic [COL_IW-1:0]  item_col_i;
    logic [CELL_AW-1:0] item_addr;
    logic               scan_in_range;
    logic [CELL_AW-1:0] scan_addr;
    logic [7:0]         run_pos;
    logic [7:0]         next_pos;
    logic               run_in;
    logic               run_more;
    logic [6:0]         len_eff;
    logic [COLS_N-1:0]  masked;
    logic               found;
    logic [COL_IW-1:0]  first_col;
    logic               differ;
    out_item_t          res_val;

    logic               cell_rd_en;
    logic [CELL_AW-1:0] cell_rd_addr;
    logic               cell_we;
    logic [CELL_AW-1:0] cell_wa;
    logic [8:0]         cell_wd;
    logic               dirty_rd_en;
    logic [ROW_IW-1:0]  dirty_rd_addr;
    logic               dirty_we;
    logic [ROW_IW-1:0]  dirty_wa;
    logic [COLS_N-1:0]  dirty_wd;

    assign item_inside = ({1'b0, item_reg.cell_row} < ROWS_LIM) &&
                         ({1'b0, item_reg.cell_col} < COLS_LIM);
    assign item_row_i  = item_reg.cell_row[ROW_IW-1:0];
    assign item_col_i  = item_reg.cell_col[COL_IW-1:0];
    assign item_addr   = cell_addr(item_row_i, item_col_i);

    assign scan_in_range = ({1'b0, scan_col_reg} < COLS_LIM);
    assign scan_addr     = cell_addr(scan_row_reg, scan_col_reg[COL_IW-1:0]);

    // The run grows while cells stay dirty and keep the first cell's extended bit.
    assign run_pos  = {1'b0, scan_col_reg} + {1'b0, len_reg};
    assign next_pos = run_pos + 8'd1;
    assign run_in   = run_pos < COLS_LIM;
    assign run_more = run_in && row_buf_reg[run_pos[COL_IW-1:0]] &&
                      (cell_q_reg[8] == run_ext_reg);
    assign len_eff  = (len_reg == 7'd0) ? 7'd1 : len_reg;
    assign differ   = cell_q_reg != item_reg.char_code;

    always_comb begin
        for (int i = 0; i < COLS_N; i++) begin
            masked[i] = dirty_q_reg[i] && (8'(i) >= {1'b0, find_col_reg});
        end
        found     = |masked;
        first_col = '0;
        for (int i = COLS_N - 1; i >= 0; i--) begin
            if (masked[i]) begin
                first_col = COL_IW'(i);
            end
        end
    end

    always_comb begin
        res_val = '0;
        case (cmd.res_sel)
            RES_ZERO: begin
                res_val = '0;
            end
            RES_READ: begin
                res_val.read_code = cell_q_reg;
                res_val.read_ok   = 1'b1;
            end
            RES_CLEAR: begin
                res_val.out_byte  = CLEAR_CMD_BYTE;
                res_val.out_valid = 1'b1;
            end
            RES_STRING: begin
                res_val.out_byte  = STRING_CMD_BYTE;
                res_val.out_valid = 1'b1;
            end
            RES_ROW: begin
                res_val.out_byte  = 8'(scan_row_reg);
                res_val.out_valid = 1'b1;
            end
            RES_COL: begin
                res_val.out_byte  = {1'b0, scan_col_reg};
                res_val.out_valid = 1'b1;
            end
            RES_INFO: begin
                res_val.out_byte  = {run_ext_reg, len_eff};
                res_val.out_valid = 1'b1;
            end
            RES_CODE: begin
                res_val.out_byte  = scan_in_range ? cell_q_reg[7:0] : 8'd0;
                res_val.out_valid = 1'b1;
            end
            RES_EMPTY: begin
                res_val.out_last = 1'b1;
            end
            default: begin
                res_val = '0;
            end
        endcase
    end

    // Memory port steering.
    always_comb begin
        cell_rd_en    = 1'b0;
        cell_rd_addr  = item_addr;
        dirty_rd_en   = 1'b0;
        dirty_rd_addr = item_row_i;
        cell_we       = 1'b0;
        cell_wa       = item_addr;
        cell_wd       = item_reg.char_code;
        dirty_we      = 1'b0;
        dirty_wa      = item_row_i;
        dirty_wd      = dirty_q_reg | (COLS_N'(1) << item_col_i);

        if (cmd.item_read) begin
            cell_rd_en  = 1'b1;
            dirty_rd_en = 1'b1;
        end
        if ((cmd.run_start || cmd.code_issue) && scan_in_range) begin
            cell_rd_en   = 1'b1;
            cell_rd_addr = scan_addr;
        end
        if (cmd.run_start) begin
            dirty_rd_en   = 1'b1;
            dirty_rd_addr = scan_row_reg;
        end
        if (cmd.run_take && (next_pos < COLS_LIM)) begin
            cell_rd_en   = 1'b1;
            cell_rd_addr = cell_addr(scan_row_reg, next_pos[COL_IW-1:0]);
        end
        if (cmd.find_issue) begin
            dirty_rd_en   = 1'b1;
            dirty_rd_addr = find_row_reg;
        end

        if (cmd.write_commit && differ) begin
            cell_we  = 1'b1;
            dirty_we = 1'b1;
        end
        if (cmd.run_finish) begin
            dirty_we = 1'b1;
            dirty_wa = scan_row_reg;
            dirty_wd = row_buf_reg;
        end
        if (cmd.sweep_step) begin
            cell_we  = !sweep_redraw_reg;
            cell_wa  = sweep_cnt_reg;
            cell_wd  = {1'b0, sweep_val_reg};
            dirty_we = sweep_cnt_reg <= LAST_ROW_CNT;
            dirty_wa = sweep_cnt_reg[ROW_IW-1:0];
            dirty_wd = sweep_redraw_reg ? '1 : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        if (cell_rd_en) begin
            cell_q_reg <= cell_mem[cell_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dirty_we) begin
            dirty_mem[dirty_wa] <= dirty_wd;
        end
        if (dirty_rd_en) begin
            dirty_q_reg <= dirty_mem[dirty_rd_addr];
        end
    end

    always_comb begin
        item_next         = s_accept ? s_item : item_reg;
        blank_next        = cfg_we ? cfg_wdata : blank_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        sweep_val_next    = sweep_val_reg;
        sweep_redraw_next = sweep_redraw_reg;
        scan_row_next     = scan_row_reg;
        scan_col_next     = scan_col_reg;
        find_row_next     = find_row_reg;
        find_col_next     = find_col_reg;
        row_buf_next      = row_buf_reg;
        len_next          = len_reg;
        run_left_next     = run_left_reg;
        run_ext_next      = run_ext_reg;
        res_next          = res_reg;
        m_valid_next      = m_valid_reg;
        m_item_next       = m_item_reg;

        if (cmd.sweep_start) begin
            sweep_cnt_next    = '0;
            sweep_val_next    = blank_reg;
            sweep_redraw_next = cmd.sweep_redraw;
            if (!cmd.sweep_redraw) begin
                run_left_next = '0;
            end
        end
        if (cmd.sweep_step && !sts.sweep_last) begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
        end

        if (cmd.find_origin) begin
            find_row_next = '0;
            find_col_next = '0;
        end
        if (cmd.find_next) begin
            find_row_next = scan_row_reg;
            find_col_next = scan_col_reg + 7'd1;
        end
        if (cmd.find_eval) begin
            if (found) begin
                scan_row_next = find_row_reg;
                scan_col_next = 7'(first_col);
            end else if (find_row_reg != LAST_ROW) begin
                find_row_next = find_row_reg + 1'b1;
                find_col_next = '0;
            end
        end

        if (cmd.run_load) begin
            row_buf_next = dirty_q_reg;
            run_ext_next = scan_in_range && cell_q_reg[8];
            len_next     = '0;
        end
        if (cmd.run_take) begin
            row_buf_next[run_pos[COL_IW-1:0]] = 1'b0;
            len_next = len_reg + 7'd1;
        end
        if (cmd.run_finish) begin
            run_left_next = len_eff;
        end
        if (cmd.code_finish) begin
            scan_col_next = scan_col_reg + 7'd1;
            if (run_left_reg != 7'd0) begin
                run_left_next = run_left_reg - 7'd1;
            end
        end

        if (cmd.res_set) begin
            res_next = res_val;
        end
        if (cmd.res_mark_last) begin
            res_next.out_last = 1'b1;
        end

        if (cmd.res_push) begin
            m_valid_next = 1'b1;
            m_item_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_reg        <= BLANK_RESET;
            sweep_cnt_reg    <= '0;
            sweep_val_reg    <= BLANK_RESET;
            sweep_redraw_reg <= 1'b0;
            scan_row_reg     <= '0;
            scan_col_reg     <= '0;
            find_row_reg     <= '0;
            find_col_reg     <= '0;
            len_reg          <= '0;
            run_left_reg     <= '0;
            run_ext_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            blank_reg        <= blank_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            sweep_val_reg    <= sweep_val_next;
            sweep_redraw_reg <= sweep_redraw_next;
            scan_row_reg     <= scan_row_next;
            scan_col_reg     <= scan_col_next;
            find_row_reg     <= find_row_next;
            find_col_reg     <= find_col_next;
            len_reg          <= len_next;
            run_left_reg     <= run_left_next;
            run_ext_reg      <= run_ext_next;
            m_valid_reg      <= m_valid_next;
        end
        item_reg    <= item_next;
        row_buf_reg <= row_buf_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    always_comb begin
        sts.op             = item_reg.op;
        sts.on_screen      = item_inside;
        sts.sweep_last     = sweep_redraw_reg ? (sweep_cnt_reg == LAST_ROW_CNT)
                                              : (sweep_cnt_reg == LAST_CELL);
        sts.find_found     = found;
        sts.find_exhausted = !found && (find_row_reg == LAST_ROW);
        sts.run_more       = run_more;
        sts.run_single     = run_left_reg <= 7'd1;
        sts.out_free       = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

FILE: design/osdrf_ctrl.sv
// Controller: sequences each operation and tracks the frame phase and clear flag.
`timescale 1ns / 1ps
`default_nettype none
module osdrf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire osdrf_pkg::dp_sts_t sts,
    output osdrf_pkg::dp_cmd_t      cmd
);
    import osdrf_pkg::*;

    typedef enum logic [11:0] {
        S_INIT      = 12'b000000000001,
        S_IDLE      = 12'b000000000010,
        S_DECODE    = 12'b000000000100,
        S_WR_CMP    = 12'b000000001000,
        S_SWEEP     = 12'b000000010000,
        S_RD_WAIT   = 12'b000000100000,
        S_FIND_RD   = 12'b000001000000,
        S_FIND_CHK  = 12'b000010000000,
        S_RUN_LOAD  = 12'b000100000000,
        S_RUN_CHK   = 12'b001000000000,
        S_CODE_WAIT = 12'b010000000000,
        S_RESULT    = 12'b100000000000
    } state_t;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_CMD   = 6'b000010,
        PH_ROW   = 6'b000100,
        PH_COL   = 6'b001000,
        PH_INFO  = 6'b010000,
        PH_CODES = 6'b100000
    } phase_t;

    // Which pull started the current search for a dirty cell.
    typedef enum logic [2:0] {
        CTX_CLEAR = 3'b001,
        CTX_IDLE  = 3'b010,
        CTX_CODES = 3'b100
    } ctx_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    ctx_t   ctx_reg, ctx_next;
    logic   clear_pending_reg, clear_pending_next;

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        cmd                = '0;
        state_next         = state_reg;
        phase_next         = phase_reg;
        ctx_next           = ctx_reg;
        clear_pending_next = clear_pending_reg;

        case (state_reg)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_WRITE: begin
                        if (sts.on_screen) begin
                            cmd.item_read = 1'b1;
                            state_next    = S_WR_CMP;
                        end else begin
                            cmd.res_set = 1'b1;
                            state_next  = S_RESULT;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.sweep_start    = 1'b1;
                        clear_pending_next = 1'b1;
                        phase_next         = PH_IDLE;
                        state_next         = S_SWEEP;
                    end
                    OP_REDRAW: begin
                        cmd.sweep_start  = 1'b1;
                        cmd.sweep_redraw = 1'b1;
                        state_next       = S_SWEEP;
                    end
                    OP_READ: begin
                        if (sts.on_screen) begin
                            cmd.item_read = 1'b1;
                            state_next    = S_RD_WAIT;
                        end else begin
                            cmd.res_set = 1'b1;
                            state_next  = S_RESULT;
                        end
                    end
                    OP_PULL: begin
                        case (phase_reg)
                            PH_IDLE: begin
                                cmd.find_origin = 1'b1;
                                state_next      = S_FIND_RD;
                                if (clear_pending_reg) begin
                                    clear_pending_next = 1'b0;
                                    cmd.res_set        = 1'b1;
                                    cmd.res_sel        = RES_CLEAR;
                                    ctx_next           = CTX_CLEAR;
                                end else begin
                                    ctx_next = CTX_IDLE;
                                end
                            end
                            PH_CMD: begin
                                cmd.res_set = 1'b1;
                                cmd.res_sel = RES_STRING;
                                phase_next  = PH_ROW;
                                state_next  = S_RESULT;
                            end
                            PH_ROW: begin
                                cmd.res_set = 1'b1;
                                cmd.res_sel = RES_ROW;
                                phase_next  = PH_COL;
                                state_next  = S_RESULT;
                            end
                            PH_COL: begin
                                cmd.res_set = 1'b1;
                                cmd.res_sel = RES_COL;
                                phase_next  = PH_INFO;
                                state_next  = S_RESULT;
                            end
                            PH_INFO: begin
                                cmd.run_start = 1'b1;
                                state_next    = S_RUN_LOAD;
                            end
                            PH_CODES: begin
                                cmd.code_issue = 1'b1;
                                state_next     = S_CODE_WAIT;
                            end
                            default: begin
                                cmd.res_set = 1'b1;
                                cmd.res_sel = RES_EMPTY;
                                phase_next  = PH_IDLE;
                                state_next  = S_RESULT;
                            end
                        endcase
                    end
                    default: begin
                        cmd.res_set = 1'b1;
                        state_next  = S_RESULT;
                    end
                endcase
            end
            S_WR_CMP: begin
                cmd.write_commit = 1'b1;
                cmd.res_set      = 1'b1;
                state_next       = S_RESULT;
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    cmd.res_set = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_RD_WAIT: begin
                cmd.res_set = 1'b1;
                cmd.res_sel = RES_READ;
                state_next  = S_RESULT;
            end
            S_FIND_RD: begin
                cmd.find_issue = 1'b1;
                state_next     = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                cmd.find_eval = 1'b1;
                if (sts.find_found) begin
                    state_next = S_RESULT;
                    case (ctx_reg)
                        CTX_IDLE: begin
                            cmd.res_set = 1'b1;
                            cmd.res_sel = RES_STRING;
                            phase_next  = PH_ROW;
                        end
                        default: begin
                            phase_next = PH_CMD;
                        end
                    endcase
                end else if (sts.find_exhausted) begin
                    state_next = S_RESULT;
                    phase_next = PH_IDLE;
                    case (ctx_reg)
                        CTX_IDLE: begin
                            cmd.res_set = 1'b1;
                            cmd.res_sel = RES_EMPTY;
                        end
                        default: begin
                            cmd.res_mark_last = 1'b1;
                        end
                    endcase
                end else begin
                    state_next = S_FIND_RD;
                end
            end
            S_RUN_LOAD: begin
                cmd.run_load = 1'b1;
                state_next   = S_RUN_CHK;
            end
            S_RUN_CHK: begin
                if (sts.run_more) begin
                    cmd.run_take = 1'b1;
                end else begin
                    cmd.run_finish = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_sel    = RES_INFO;
                    phase_next     = PH_CODES;
                    state_next     = S_RESULT;
                end
            end
            S_CODE_WAIT: begin
                cmd.res_set     = 1'b1;
                cmd.res_sel     = RES_CODE;
                cmd.code_finish = 1'b1;
                if (sts.run_single) begin
                    cmd.find_next = 1'b1;
                    ctx_next      = CTX_CODES;
                    state_next    = S_FIND_RD;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_INIT;
            phase_reg         <= PH_IDLE;
            ctx_reg           <= CTX_IDLE;
            clear_pending_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            ctx_reg           <= ctx_next;
            clear_pending_reg <= clear_pending_next;
        end
    end

    // The store is being initialized right after reset, so no beat may be taken.
    a_init_not_ready: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during reset initialization");

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_push |-> sts.out_free)
        else $error("result pushed into an occupied output register");

    a_clear_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && sts.op == OP_CLEAR)
        |=> (clear_pending_reg && phase_reg == PH_IDLE))
        else $error("clear did not reset the frame");

    a_row_to_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECODE && sts.op == OP_PULL && phase_reg == PH_ROW)
        |=> (phase_reg == PH_COL))
        else $error("row byte not followed by column phase");

endmodule
`default_nettype wire

FILE: design/osd_dirty_run_frame_encoder.sv
// Top level of the OSD character store with dirty-run frame encoding.
`timescale 1ns / 1ps
`default_nettype none
// Character screen store of ROWS_N x COLS_N cells with a dirty-run update
// frame. One operation is taken per input beat and gives one result beat;
// the block takes the next beat once the current operation has finished,
// while its result may still wait in the output register. After reset the
// store is filled with the blank code, one cell per cycle, before the first
// beat is taken. A clear sweeps the whole store, and a forced redraw sweeps
// the dirty rows, marking every cell dirty. The length byte walks the run
// through the single store read port, one cell per cycle; finding the next
// dirty run reads one dirty row at a time, issuing the read in S_FIND_RD and
// checking it in S_FIND_CHK.
module osd_dirty_run_frame_encoder #(
    parameter int ROWS_N = 22,
    parameter int COLS_N = 60
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire osdrf_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output osdrf_pkg::out_item_t      m_item,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata
);
    import osdrf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    s_accept;

    assign s_accept = s_valid && s_ready;

    osdrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    osdrf_datapath #(
        .ROWS_N (ROWS_N),
        .COLS_N (COLS_N)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_accept  (s_accept),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
`default_nettype wire
